/* hdl/sic_pkg.sv */
// Package for the SIC receiver candidate table.
// Types, status codes, op codes and register indexes. No dependencies.
`timescale 1ns / 1ps
package sic_pkg;
	localparam int MaxSignals = 8;
	localparam int PowW = 48;
	localparam int IdW = 16;
	localparam int SumW = 56;

	typedef enum logic [1:0] {
		OP_ARRIVE = 2'd0,
		OP_DECIDE = 2'd1,
		OP_TX_START = 2'd2,
		OP_TX_END = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_ASLEEP = 4'd1,
		ST_TRANSMIT = 4'd2,
		ST_UNDECODABLE = 4'd3,
		ST_WEAK = 4'd4,
		ST_CHANNEL = 4'd5,
		ST_PERIOD = 4'd6,
		ST_MODULATION = 4'd7,
		ST_FULL = 4'd8
	} status_t;

	localparam logic [2:0] REG_SLEEP = 3'd0;
	localparam logic [2:0] REG_CHANNEL = 3'd1;
	localparam logic [2:0] REG_PERIOD = 3'd2;
	localparam logic [2:0] REG_MODULATION = 3'd3;
	localparam logic [2:0] REG_SENSITIVITY = 3'd4;
	localparam logic [2:0] REG_THRESHOLD = 3'd5;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic [PowW-1:0] power;
		logic [PowW-1:0] end_time;
		logic valid;
	} entry_t;

	// Commands broadcast to every cell.
	typedef struct packed {
		logic insert;
		logic expire;
		logic shift;
		logic [PowW-1:0] now;
		entry_t item;
	} cell_cmd_t;
endpackage

/* hdl/sic_cell.sv */
// One slot of the candidate table chain.
// Depends on sic_pkg. Inserts in order, compacts on expiry, rotates for the walk.
`timescale 1ns / 1ps
module sic_cell (
	input  logic clk,
	input  logic arst_n,
	input  sic_pkg::cell_cmd_t cmd,
	input  sic_pkg::entry_t prev,
	input  logic prev_ins,
	input  sic_pkg::entry_t next,
	input  logic prev_drop,
	output sic_pkg::entry_t cur,
	output logic ins,
	output logic drop
);
	sic_pkg::entry_t e_q;
	assign cur = e_q;
	// insert point: new item is stronger than this entry, or this slot is empty
	assign ins = !e_q.valid || (e_q.power < cmd.item.power);
	// this entry or one above it vanishes during compaction
	assign drop = prev_drop || !e_q.valid || (cmd.now > e_q.end_time);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else if (cmd.insert) begin
			if (prev_ins) e_q <= prev;
			else if (ins) e_q <= cmd.item;
		end else if (cmd.expire) begin
			if (drop) e_q <= next;
		end else if (cmd.shift) begin
			e_q <= next;
		end
	end
endmodule

/* hdl/sic_receiver_candidate_table.sv */
// Top level of the SIC receiver candidate table.
// Depends on sic_pkg and sic_cell. Control sequencer, sums and threshold test.
`timescale 1ns / 1ps
// A refused arrival and a transmit op give their result in the cycle after the item
// is accepted; an inserted arrival first passes through S_DONE, where the cells
// take it. A receive decision runs MAX_SIGNALS expiry compaction steps, one full
// rotation of the cell chain to sum the powers, then a walk in which each entry
// takes a subtract step with a registered threshold product and then a compare
// step, and the rest of a second rotation so the table ends in its original order.
// The chain of cells shifts one slot per cycle. The next item is accepted the
// cycle after the result is taken, so output stalls add directly.
module sic_receiver_candidate_table #(
	parameter int MAX_SIGNALS = sic_pkg::MaxSignals
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] op,
	input  logic [15:0] signal_id,
	input  logic [47:0] signal_power,
	input  logic [7:0] signal_channel,
	input  logic [19:0] signal_period,
	input  logic [7:0] signal_modulation,
	input  logic [47:0] end_time,
	input  logic [47:0] now,
	input  logic [47:0] noise_power,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] status,
	output logic [3:0] stored_count,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [47:0] cfg_data
);
	localparam int CW = $clog2(MAX_SIGNALS + 1);
	localparam int PW = sic_pkg::PowW;
	localparam int SW = sic_pkg::SumW;
	localparam int PRW = SW + 16;

	typedef enum logic [2:0] {S_IDLE, S_EXPIRE, S_SUM, S_WALK, S_TEST, S_ROT, S_DONE} state_t;

	logic sleep_q;
	logic [7:0] chan_q, mod_q;
	logic [19:0] period_q;
	logic [PW-1:0] sens_q;
	logic [15:0] thr_q;
	logic tx_q;
	logic [15:0] tx_id_q;

	state_t st_q;
	logic [CW-1:0] cnt_q, step_q;
	logic [1:0] op_q;
	logic [15:0] id_q;
	logic [PW-1:0] now_q;
	logic [PW-1:0] signal_power_q, end_q;
	logic [SW-1:0] res_q;
	logic [SW-1:0] res_next;
	logic [PW-1:0] pw_s1;
	logic [15:0] eid_s1;
	logic [PRW-1:0] prod_s1;
	logic [3:0] status_q;
	logic out_q;
	logic ins_q;

	sic_pkg::cell_cmd_t cmd;
	sic_pkg::entry_t cur [MAX_SIGNALS];
	logic ins [MAX_SIGNALS];
	logic drop [MAX_SIGNALS];
	sic_pkg::entry_t empty_e;
	logic [CW-1:0] nvalid;

	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != S_IDLE) || out_q;
	assign out_valid = out_q;
	assign status = status_q;

	always_comb begin
		nvalid = '0;
		for (int i = 0; i < MAX_SIGNALS; i++) nvalid = nvalid + CW'(cur[i].valid);
	end
	assign stored_count = 4'(nvalid);

	assign empty_e = '0;
	assign res_next = res_q - SW'(cur[0].power);

	always_comb begin
		cmd = '0;
		cmd.insert = ins_q;
		cmd.expire = (st_q == S_EXPIRE);
		cmd.shift = (st_q == S_SUM) || (st_q == S_WALK && step_q != cnt_q)
			|| (st_q == S_ROT && step_q != CW'(MAX_SIGNALS));
		cmd.now = now_q;
		cmd.item.id = id_q;
		cmd.item.power = signal_power_q;
		cmd.item.end_time = end_q;
		cmd.item.valid = 1'b1;
	end

	for (genvar g = 0; g < MAX_SIGNALS; g++) begin : g_cell
		sic_pkg::entry_t pv, nx;
		logic pins, pdrop;
		if (g == 0) begin : g_first
			assign pv = empty_e;
			assign pins = 1'b0;
			assign pdrop = 1'b0;
		end else begin : g_mid
			assign pv = cur[g-1];
			assign pins = ins[g-1];
			assign pdrop = drop[g-1];
		end
		if (g == MAX_SIGNALS - 1) begin : g_last
			// rotation wraps the head back to the tail
			assign nx = cmd.shift ? cur[0] : empty_e;
		end else begin : g_inner
			assign nx = cur[g+1];
		end
		sic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .prev(pv), .prev_ins(pins),
			.next(nx), .prev_drop(pdrop), .cur(cur[g]), .ins(ins[g]), .drop(drop[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_q <= 1'b0; chan_q <= '0; period_q <= 20'd91; mod_q <= '0;
			sens_q <= 48'd631; thr_q <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				sic_pkg::REG_SLEEP: sleep_q <= cfg_data[0];
				sic_pkg::REG_CHANNEL: chan_q <= cfg_data[7:0];
				sic_pkg::REG_PERIOD: period_q <= cfg_data[19:0];
				sic_pkg::REG_MODULATION: mod_q <= cfg_data[7:0];
				sic_pkg::REG_SENSITIVITY: sens_q <= cfg_data;
				sic_pkg::REG_THRESHOLD: thr_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// threshold test product of the residual left after this entry, registered
	always_ff @(posedge clk) begin
		pw_s1 <= cur[0].power;
		eid_s1 <= cur[0].id;
		prod_s1 <= PRW'(res_next) * PRW'(thr_q);
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			id_q <= signal_id; now_q <= now; signal_power_q <= signal_power;
			end_q <= end_time; res_q <= SW'(noise_power);
		end else if (st_q == S_SUM) begin
			res_q <= res_q + SW'(cur[0].power & {PW{cur[0].valid}});
		end else if (st_q == S_WALK) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_q <= 1'b0; status_q <= '0; tx_q <= 1'b0;
			tx_id_q <= '0; cnt_q <= '0; step_q <= '0; op_q <= '0; ins_q <= 1'b0;
		end else begin
			if (out_q && !out_stall) out_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					op_q <= op;
					case (op)
						sic_pkg::OP_ARRIVE: begin
							if (sleep_q) begin
								status_q <= sic_pkg::ST_ASLEEP; out_q <= 1'b1;
							end else if (tx_q) begin
								status_q <= sic_pkg::ST_TRANSMIT; out_q <= 1'b1;
							end else if (signal_power < sens_q) begin
								status_q <= sic_pkg::ST_WEAK; out_q <= 1'b1;
							end else if (signal_channel != chan_q) begin
								status_q <= sic_pkg::ST_CHANNEL; out_q <= 1'b1;
							end else if (signal_period != period_q) begin
								status_q <= sic_pkg::ST_PERIOD; out_q <= 1'b1;
							end else if (signal_modulation != mod_q) begin
								status_q <= sic_pkg::ST_MODULATION; out_q <= 1'b1;
							end else if (cur[MAX_SIGNALS-1].valid) begin
								status_q <= sic_pkg::ST_FULL; out_q <= 1'b1;
							end else begin
								status_q <= sic_pkg::ST_OK;
								ins_q <= 1'b1; st_q <= S_DONE;
							end
						end
						sic_pkg::OP_DECIDE: begin
							if (sleep_q) begin
								status_q <= sic_pkg::ST_ASLEEP; out_q <= 1'b1;
							end else if (tx_q) begin
								status_q <= sic_pkg::ST_TRANSMIT; out_q <= 1'b1;
							end else begin
								st_q <= S_EXPIRE; step_q <= '0;
							end
						end
						sic_pkg::OP_TX_START: begin
							out_q <= 1'b1;
							if (sleep_q) status_q <= sic_pkg::ST_ASLEEP;
							else begin
								status_q <= sic_pkg::ST_OK; tx_q <= 1'b1; tx_id_q <= signal_id;
							end
						end
						default: begin
							out_q <= 1'b1; status_q <= sic_pkg::ST_OK;
							if (tx_q && tx_id_q == signal_id) tx_q <= 1'b0;
						end
					endcase
				end
				S_EXPIRE: begin
					if (step_q == CW'(MAX_SIGNALS - 1)) begin
						st_q <= S_SUM; step_q <= '0;
					end else step_q <= step_q + 1'b1;
				end
				S_SUM: begin
					if (step_q == CW'(MAX_SIGNALS - 1)) begin
						st_q <= S_WALK; step_q <= '0; cnt_q <= nvalid;
					end else step_q <= step_q + 1'b1;
				end
				S_WALK: begin
					if (step_q == cnt_q) begin
						status_q <= sic_pkg::ST_UNDECODABLE; st_q <= S_ROT;
					end else st_q <= S_TEST;
				end
				S_TEST: begin
					step_q <= step_q + 1'b1;
					if ({16'd0, pw_s1, 8'd0} < prod_s1) begin
						status_q <= sic_pkg::ST_UNDECODABLE; st_q <= S_ROT;
					end else if (eid_s1 == id_q) begin
						status_q <= sic_pkg::ST_OK; st_q <= S_ROT;
					end else st_q <= S_WALK;
				end
				// finish the rotation so the table is back in power order
				S_ROT: begin
					if (step_q == CW'(MAX_SIGNALS)) begin
						out_q <= 1'b1; st_q <= S_IDLE;
					end else step_q <= step_q + 1'b1;
				end
				S_DONE: begin
					ins_q <= 1'b0;
					if (op_q == sic_pkg::OP_ARRIVE && !out_q) out_q <= 1'b1;
					if (!out_q || !out_stall) st_q <= (op_q == sic_pkg::OP_ARRIVE && !out_q)
						? S_DONE : S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* tb/sv/testbench.sv */
// Testbench for the SIC receiver candidate table.
// Drives random and directed ops, predicts status and table count, and compares each result.
// Depends on sic_pkg and the RTL of sic_receiver_candidate_table.
`timescale 1ns / 1ps
class sic_scoreboard;
	bit sleep_on;
	bit [7:0] chan;
	bit [19:0] period;
	bit [7:0] modul;
	bit [47:0] sens;
	bit [15:0] thresh;
	bit [15:0] t_id[8];
	bit [47:0] t_pow[8];
	bit [47:0] t_end[8];
	int count;
	bit tx_busy;
	bit [15:0] tx_id;
	bit [3:0] pend_status[$];
	bit [3:0] pend_count[$];
	int errors;

	function new();
		sleep_on = 0; chan = 0; period = 91; modul = 0; sens = 631; thresh = 256;
		count = 0; tx_busy = 0; tx_id = 0; errors = 0;
	endfunction

	function void write_reg(bit [2:0] idx, bit [47:0] d);
		case (idx)
			sic_pkg::REG_SLEEP: sleep_on = d[0];
			sic_pkg::REG_CHANNEL: chan = d[7:0];
			sic_pkg::REG_PERIOD: period = d[19:0];
			sic_pkg::REG_MODULATION: modul = d[7:0];
			sic_pkg::REG_SENSITIVITY: sens = d;
			sic_pkg::REG_THRESHOLD: thresh = d[15:0];
			default: ;
		endcase
	endfunction

	function bit passes(bit [47:0] p, bit [63:0] resid);
		bit [127:0] prod;
		prod = resid * thresh;
		if (thresh == 0) return 1;
		if (prod[127:64] != 0) return 0;
		return {p, 8'd0} >= prod;
	endfunction

	function void note_item(sic_pkg::op_t o, bit [15:0] id, bit [47:0] pw, bit [7:0] ch,
			bit [19:0] per, bit [7:0] md, bit [47:0] et, bit [47:0] tnow, bit [47:0] noise);
		sic_pkg::status_t st;
		int k, w;
		bit [63:0] resid;
		st = sic_pkg::ST_OK;
		case (o)
			sic_pkg::OP_ARRIVE: begin
				if (sleep_on) st = sic_pkg::ST_ASLEEP;
				else if (tx_busy) st = sic_pkg::ST_TRANSMIT;
				else if (pw < sens) st = sic_pkg::ST_WEAK;
				else if (ch != chan) st = sic_pkg::ST_CHANNEL;
				else if (per != period) st = sic_pkg::ST_PERIOD;
				else if (md != modul) st = sic_pkg::ST_MODULATION;
				else if (count >= 8) st = sic_pkg::ST_FULL;
				else begin
					k = count;
					for (int i = 0; i < count; i++)
						if (t_pow[i] < pw && k == count) k = i;
					for (int i = count; i > k; i--) begin
						t_id[i] = t_id[i-1]; t_pow[i] = t_pow[i-1]; t_end[i] = t_end[i-1];
					end
					t_id[k] = id; t_pow[k] = pw; t_end[k] = et;
					count++;
				end
			end
			sic_pkg::OP_DECIDE: begin
				if (sleep_on) st = sic_pkg::ST_ASLEEP;
				else if (tx_busy) st = sic_pkg::ST_TRANSMIT;
				else begin
					w = 0;
					for (int r = 0; r < count; r++)
						if (!(tnow > t_end[r])) begin
							t_id[w] = t_id[r]; t_pow[w] = t_pow[r]; t_end[w] = t_end[r];
							w++;
						end
					count = w;
					resid = noise;
					for (int i = 0; i < count; i++) resid += t_pow[i];
					st = sic_pkg::ST_UNDECODABLE;
					for (int i = 0; i < count; i++) begin
						resid -= t_pow[i];
						if (!passes(t_pow[i], resid)) break;
						if (t_id[i] == id) begin
							st = sic_pkg::ST_OK;
							break;
						end
					end
				end
			end
			sic_pkg::OP_TX_START: begin
				if (sleep_on) st = sic_pkg::ST_ASLEEP;
				else begin
					tx_busy = 1; tx_id = id;
				end
			end
			default: if (tx_busy && tx_id == id) tx_busy = 0;
		endcase
		pend_status.push_back(st);
		pend_count.push_back(count[3:0]);
	endfunction

	function void check_result(bit [3:0] st, bit [3:0] cnt);
		bit [3:0] es, ec;
		if (pend_status.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result status=%0d count=%0d", st, cnt);
			return;
		end
		es = pend_status.pop_front();
		ec = pend_count.pop_front();
		if (es != st || ec != cnt) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
					es, st, ec, cnt);
		end
	endfunction
endclass

module testbench;
	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] op = 0;
	logic [15:0] signal_id = 0;
	logic [47:0] signal_power = 0, end_time = 0, now = 0, noise_power = 0;
	logic [7:0] signal_channel = 0, signal_modulation = 0;
	logic [19:0] signal_period = 0;
	logic [3:0] status, stored_count;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [47:0] cfg_data = 0;

	sic_scoreboard table_model;
	int idle_cycles = 0;
	int cyc = 0;
	bit [7:0] cur_chan = 0, cur_mod = 0;
	bit [19:0] cur_period = 91;
	bit [47:0] clock_now = 1000;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	sic_receiver_candidate_table DUT (.*);

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && out_valid && !out_stall) table_model.check_result(status, stored_count);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		case ((cyc / 300) % 3)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk)
		if (idle_cycles > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end

	task automatic write_cfg(bit [2:0] idx, bit [47:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		table_model.write_reg(idx, d);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (table_model.pend_status.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send(sic_pkg::op_t o, bit [15:0] id, bit [47:0] pw, bit [7:0] ch,
			bit [19:0] per, bit [7:0] md, bit [47:0] et, bit [47:0] tn, bit [47:0] noise);
		in_valid <= 1; op <= o; signal_id <= id; signal_power <= pw;
		signal_channel <= ch; signal_period <= per; signal_modulation <= md;
		end_time <= et; now <= tn; noise_power <= noise;
		do @(posedge clk); while (in_stall);
		table_model.note_item(o, id, pw, ch, per, md, et, tn, noise);
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic random_item();
		int r;
		bit [47:0] pw;
		bit [15:0] id;
		r = $urandom_range(0, 99);
		id = 16'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) id = 16'($urandom);
		case ($urandom_range(0, 3))
			0: pw = 48'($urandom_range(600, 5000));
			1: pw = 48'({$urandom, $urandom});
			2: pw = 48'($urandom_range(1000, 1003));
			default: pw = {16'd0, $urandom};
		endcase
		if (r < 50) begin
			if ($urandom_range(0, 9) == 0)
				send(sic_pkg::OP_ARRIVE, id, pw, 8'($urandom), 20'($urandom), 8'($urandom),
					48'({$urandom, $urandom}), 0, 0);
			else
				send(sic_pkg::OP_ARRIVE, id, pw, cur_chan, cur_period, cur_mod,
					clock_now + 48'($urandom_range(0, 400)), 0, 0);
		end else if (r < 80) begin
			clock_now += 48'($urandom_range(0, 60));
			send(sic_pkg::OP_DECIDE, id, 48'($urandom), 8'($urandom), 20'($urandom),
				8'($urandom), 48'($urandom),
				$urandom_range(0, 7) == 0 ? 48'({$urandom, $urandom}) : clock_now,
				$urandom_range(0, 3) == 0 ? 48'({$urandom, $urandom})
					: 48'($urandom_range(0, 2000)));
		end else if (r < 88) begin
			send(sic_pkg::OP_TX_START, id, 0, 0, 0, 0, 0, 0, 0);
		end else begin
			send(sic_pkg::OP_TX_END,
				$urandom_range(0, 3) == 0 ? 16'($urandom) : table_model.tx_id,
				0, 0, 0, 0, 0, 0, 0);
		end
	endtask

	initial begin
		table_model = new();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, filters, full table, expiry edges, tx
		send(sic_pkg::OP_DECIDE, 16'd1, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
		send(sic_pkg::OP_ARRIVE, 16'd1, 48'd630, 0, 91, 0, 100, 0, 0);
		send(sic_pkg::OP_ARRIVE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 0, 91, 0,
			48'hFFFF_FFFF_FFFF, 0, 0);
		send(sic_pkg::OP_ARRIVE, 16'd2, 48'd631, 8'hFF, 91, 0, 100, 0, 0);
		send(sic_pkg::OP_ARRIVE, 16'd2, 48'd631, 0, 20'hFFFFF, 0, 100, 0, 0);
		send(sic_pkg::OP_ARRIVE, 16'd2, 48'd631, 0, 91, 8'hFF, 100, 0, 0);
		for (int i = 0; i < 8; i++)
			send(sic_pkg::OP_ARRIVE, 16'(10 + i), 48'd5000, 0, 91, 0, 48'(100 + i), 0, 0);
		send(sic_pkg::OP_DECIDE, 16'd10, 0, 0, 0, 0, 0, 48'd100, 48'd0);
		send(sic_pkg::OP_DECIDE, 16'hFFFF, 0, 0, 0, 0, 0, 48'd101, 48'd0);
		send(sic_pkg::OP_TX_START, 16'd7, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_ARRIVE, 16'd3, 48'd9000, 0, 91, 0, 500, 0, 0);
		send(sic_pkg::OP_DECIDE, 16'd7, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_TX_END, 16'd8, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_TX_END, 16'd7, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_DECIDE, 16'hFFFF, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
		in_valid <= 0;
		drain();

		write_cfg(sic_pkg::REG_SLEEP, 1);
		send(sic_pkg::OP_ARRIVE, 1, 5000, 0, 91, 0, 10, 0, 0);
		send(sic_pkg::OP_DECIDE, 1, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_TX_START, 1, 0, 0, 0, 0, 0, 0, 0);
		send(sic_pkg::OP_TX_END, 1, 0, 0, 0, 0, 0, 0, 0);
		in_valid <= 0;
		drain();
		write_cfg(sic_pkg::REG_SLEEP, 0);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_cfg(sic_pkg::REG_THRESHOLD, 0);
					write_cfg(sic_pkg::REG_SENSITIVITY, 0);
				end
				1: begin
					write_cfg(sic_pkg::REG_THRESHOLD, 48'hFFFF);
					write_cfg(sic_pkg::REG_SENSITIVITY, 48'hFFFF_FFFF_FFFF);
				end
				2: begin
					cur_chan = 8'hFF; cur_mod = 8'hFF; cur_period = 20'hFFFFF;
					write_cfg(sic_pkg::REG_THRESHOLD, 48'd128);
					write_cfg(sic_pkg::REG_SENSITIVITY, 600);
				end
				default: begin
					cur_chan = 8'($urandom); cur_mod = 8'($urandom); cur_period = 20'($urandom);
					write_cfg(sic_pkg::REG_THRESHOLD, 48'($urandom_range(0, 1024)));
					write_cfg(sic_pkg::REG_SENSITIVITY, 48'($urandom_range(0, 1200)));
				end
			endcase
			write_cfg(sic_pkg::REG_CHANNEL, 48'(cur_chan));
			write_cfg(sic_pkg::REG_MODULATION, 48'(cur_mod));
			write_cfg(sic_pkg::REG_PERIOD, 48'(cur_period));
			for (int n = 0; n < 245; n++) begin
				random_item();
				idle_gap();
			end
			in_valid <= 0;
			drain();
		end

		repeat (200) @(posedge clk);
		if (table_model.errors == 0 && table_model.pend_status.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
